/* hdl/p1305_pkg.sv */
`default_nettype none
package p1305_pkg;

  localparam int NLimb = 5;
  localparam int LimbW = 26;
  localparam int AccW  = 27;
  localparam int AddW  = 28;
  localparam int ProdW = AddW + LimbW;
  localparam int ColW  = 62;
  localparam int TmpW  = 40;
  localparam int KeyW  = 64;
  localparam int BlkW  = 128;
  localparam int HW    = 131;

  localparam logic [BlkW-1:0] RClamp = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

  typedef enum logic [1:0] {
    CFG_R_LOW,
    CFG_R_HIGH,
    CFG_S_LOW,
    CFG_S_HIGH
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DRAIN,
    ST_CARRY1,
    ST_CARRY2,
    ST_CARRY3,
    ST_PADCHK,
    ST_TAG1,
    ST_TAG2,
    ST_TAG3,
    ST_TAG4
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       load_pad;
    logic       prep;
    logic       mul;
    logic [2:0] k;
    logic       carry_d;
    logic       carry_t;
    logic       carry_acc;
    logic       tag1;
    logic       tag2;
    logic       tag3;
    logic       tag4;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pend_nz;
  } status_t;

  // one parallel carry pass over five limbs, top carry folded back times five
  function automatic logic [NLimb-1:0][TmpW-1:0] carry_pass(
    input logic [NLimb-1:0][ColW-1:0] v
  );
    logic [NLimb-1:0][TmpW-1:0] res;
    logic [ColW-LimbW-1:0]      c;
    for (int i = 0; i < NLimb; i++) begin
      if (i == 0) begin
        c = v[NLimb-1][ColW-1:LimbW];
        res[i] = TmpW'(v[i][LimbW-1:0]) + TmpW'(c) + TmpW'({c, 2'b00});
      end else begin
        c = v[i-1][ColW-1:LimbW];
        res[i] = TmpW'(v[i][LimbW-1:0]) + TmpW'(c);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* hdl/p1305_ctrl.sv */
`default_nettype none
module p1305_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              final_chunk,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire p1305_pkg::status_t st,
  output p1305_pkg::cmd_t        cmd
);
  import p1305_pkg::*;

  state_t     state, state_next;
  logic [2:0] k, k_next;
  logic       fin, fin_next;
  logic       ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      fin       <= fin_next;
      out_valid <= ov_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    k_next     = k;
    fin_next   = fin;
    ov_next    = out_valid && out_stall;
    cmd        = '0;
    cmd.k      = k;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          fin_next    = final_chunk;
          if (st.full) begin
            state_next = ST_PREP;
          end else if (final_chunk) begin
            state_next = ST_PADCHK;
          end
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        k_next     = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (k == 3'(NLimb - 1)) begin
          k_next     = '0;
          state_next = ST_DRAIN;
        end else begin
          k_next = k + 3'd1;
        end
      end
      ST_DRAIN: state_next = ST_CARRY1;
      ST_CARRY1: begin
        cmd.carry_d = 1'b1;
        state_next  = ST_CARRY2;
      end
      ST_CARRY2: begin
        cmd.carry_t = 1'b1;
        state_next  = ST_CARRY3;
      end
      ST_CARRY3: begin
        cmd.carry_acc = 1'b1;
        state_next    = fin ? ST_PADCHK : ST_IDLE;
      end
      ST_PADCHK: begin
        if (st.pend_nz) begin
          cmd.load_pad = 1'b1;
          state_next   = ST_PREP;
        end else begin
          state_next = ST_TAG1;
        end
      end
      ST_TAG1: begin
        cmd.tag1   = 1'b1;
        state_next = ST_TAG2;
      end
      ST_TAG2: begin
        cmd.tag2   = 1'b1;
        state_next = ST_TAG3;
      end
      ST_TAG3: begin
        cmd.tag3   = 1'b1;
        state_next = ST_TAG4;
      end
      ST_TAG4: begin
        if (!out_valid || !out_stall) begin
          cmd.tag4   = 1'b1;
          ov_next    = 1'b1;
          fin_next   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/p1305_dp.sv */
`default_nettype none
module p1305_dp (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic [63:0] chunk_low,
  input  wire logic [63:0] chunk_high,
  input  wire logic [4:0]  byte_count,
  input  wire p1305_pkg::cmd_t cmd,
  output p1305_pkg::status_t   st,
  output logic [63:0]      tag_low,
  output logic [63:0]      tag_high
);
  import p1305_pkg::*;

  logic [KeyW-1:0] r_low, r_high, s_low, s_high;
  logic [BlkW-1:0] pend, blk;
  logic [3:0]      cnt;
  logic            hibit;

  logic [NLimb-1:0][AccW-1:0]  acc;
  logic [NLimb-1:0][AddW-1:0]  a;
  logic [NLimb-1:0][ProdW-1:0] prod;
  logic [NLimb-1:0][ColW-1:0]  d;
  logic [NLimb-1:0][TmpW-1:0]  t;
  logic                        pv;
  logic [2:0]                  pk;

  logic [HW-1:0]   hw, hf;
  logic [BlkW-1:0] hr;

  // chunk merge
  logic [4:0]            n;
  logic [5:0]            total;
  logic [BlkW-1:0]       chunk_in;
  logic [BlkW-1:0]       chunk_m;
  logic [2*BlkW-1:0]     comb;

  always_comb begin
    n = (byte_count > 5'd16) ? 5'd16 : byte_count;
    total = 6'(cnt) + 6'(n);
    chunk_in = {chunk_high, chunk_low};
    for (int b = 0; b < 16; b++) begin
      chunk_m[8*b +: 8] = (5'(b) < n) ? chunk_in[8*b +: 8] : 8'h00;
    end
    comb = {{BlkW{1'b0}}, pend} | ({{BlkW{1'b0}}, chunk_m} << {cnt, 3'b000});
    st.full    = (total >= 6'd16);
    st.pend_nz = (cnt != 4'd0);
  end

  logic [BlkW-1:0]             rc;
  logic [NLimb-1:0][LimbW-1:0] rl;
  logic [NLimb-1:0][LimbW-1:0] bl;

  always_comb begin
    rc = {r_high, r_low} & RClamp;
    for (int i = 0; i < NLimb - 1; i++) begin
      rl[i] = rc[LimbW*i +: LimbW];
      bl[i] = blk[LimbW*i +: LimbW];
    end
    rl[NLimb-1] = LimbW'(rc[BlkW-1:LimbW*(NLimb-1)]);
    bl[NLimb-1] = {1'b0, hibit, blk[BlkW-1:LimbW*(NLimb-1)]};
  end

  // column routing: product j under r limb k lands in column j+k, folded times five
  logic [NLimb-1:0][ColW-1:0] addend;
  always_comb begin
    for (int i = 0; i < NLimb; i++) begin
      addend[i] = '0;
      for (int j = 0; j < NLimb; j++) begin
        if (j <= i && pk == 3'(i - j)) begin
          addend[i] = addend[i] | ColW'(prod[j]);
        end
        if (j > i && pk == 3'(i - j + NLimb)) begin
          addend[i] = addend[i] | (ColW'(prod[j]) + ColW'({prod[j], 2'b00}));
        end
      end
    end
  end

  logic [NLimb-1:0][TmpW-1:0] cp_d, cp_t;
  logic [NLimb-1:0][ColW-1:0] t_ext;
  logic [HW:0]                g;
  logic [HW-1:0]              hsum;

  always_comb begin
    for (int i = 0; i < NLimb; i++) begin
      t_ext[i] = ColW'(t[i]);
    end
    cp_d = carry_pass(d);
    cp_t = carry_pass(t_ext);
    hsum = '0;
    for (int i = 0; i < NLimb; i++) begin
      hsum = hsum + (HW'(acc[i]) << (LimbW * i));
    end
    g = (HW + 1)'(hf) + (HW + 1)'(5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_low  <= '0;
      r_high <= '0;
      s_low  <= '0;
      s_high <= '0;
      pend   <= '0;
      cnt    <= '0;
      acc    <= '0;
      pv     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_R_LOW:  r_low  <= cfg_data;
          CFG_R_HIGH: r_high <= cfg_data;
          CFG_S_LOW:  s_low  <= cfg_data;
          CFG_S_HIGH: s_high <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_in) begin
        if (st.full) begin
          blk   <= comb[BlkW-1:0];
          hibit <= 1'b1;
          pend  <= comb[2*BlkW-1:BlkW];
          cnt   <= 4'(total - 6'd16);
        end else begin
          pend <= comb[BlkW-1:0];
          cnt  <= total[3:0];
        end
      end
      if (cmd.load_pad) begin
        blk   <= pend | ({{(BlkW-1){1'b0}}, 1'b1} << {cnt, 3'b000});
        hibit <= 1'b0;
        pend  <= '0;
        cnt   <= '0;
      end
      if (cmd.prep) begin
        for (int i = 0; i < NLimb; i++) begin
          a[i] <= AddW'(acc[i]) + AddW'(bl[i]);
        end
        d <= '0;
      end
      pv <= cmd.mul;
      pk <= cmd.k;
      if (cmd.mul) begin
        for (int j = 0; j < NLimb; j++) begin
          prod[j] <= ProdW'(a[j]) * ProdW'(rl[cmd.k]);
        end
      end
      if (pv) begin
        for (int i = 0; i < NLimb; i++) begin
          d[i] <= d[i] + addend[i];
        end
      end
      if (cmd.carry_d) t <= cp_d;
      if (cmd.carry_t) t <= cp_t;
      if (cmd.carry_acc) begin
        for (int i = 0; i < NLimb; i++) begin
          acc[i] <= cp_t[i][AccW-1:0];
        end
      end
      if (cmd.tag1) hw <= hsum;
      if (cmd.tag2) hf <= HW'(hw[HW-2:0]) + HW'({hw[HW-1], 2'b00}) + HW'(hw[HW-1]);
      if (cmd.tag3) hr <= g[HW-1] ? g[BlkW-1:0] : hf[BlkW-1:0];
      if (cmd.tag4) begin
        {tag_high, tag_low} <= hr + {s_high, s_low};
        acc <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/poly1305_authenticator.sv */
// Flow: a chunk that leaves no full block is only merged into the pending bytes; one
// that fills a block runs an operand add, 5 multiply issues on five 28x26 multipliers,
// a drain and 3 carry passes. A final chunk adds a pad check and the same steps for a
// padded block, then the final reduction and key addition; the tag sits in an output register.
// Reset (rst, synchronous): key registers, accumulator, pending count cleared.
`default_nettype none
module poly1305_authenticator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] chunk_low,
  input  wire logic [63:0] chunk_high,
  input  wire logic [4:0]  byte_count,
  input  wire logic        final_chunk,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      tag_low,
  output logic [63:0]      tag_high
);
  import p1305_pkg::*;

  cmd_t    cmd;
  status_t st;

  p1305_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .final_chunk (final_chunk),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .st          (st),
    .cmd         (cmd)
  );

  p1305_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chunk_low  (chunk_low),
    .chunk_high (chunk_high),
    .byte_count (byte_count),
    .cmd        (cmd),
    .st         (st),
    .tag_low    (tag_low),
    .tag_high   (tag_high)
  );

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import p1305_pkg::*;

  localparam int WatchLimit = 20000;
  localparam logic [129:0] PrimeP = {2'b11, {124{1'b1}}, 4'b1011};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] chunk_low = '0;
  logic [63:0] chunk_high = '0;
  logic [4:0]  byte_count = '0;
  logic        final_chunk = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] tag_low;
  logic [63:0] tag_high;

  poly1305_authenticator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [63:0]  key_r_low, key_r_high, key_s_low, key_s_high;
  logic [129:0] acc;
  logic [7:0]   held [16];
  int unsigned  held_n;
  logic [127:0] tags_due [$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           stall_left = 0;
  bit           stall_mode = 0;

  function automatic logic [129:0] mulmod(logic [129:0] a, logic [127:0] b);
    logic [259:0] p;
    p = 260'(a) * 260'(b);
    return 130'(p % 260'(PrimeP));
  endfunction

  task automatic absorb(logic hibit);
    logic [127:0] blk, rc;
    logic [130:0] sum;
    for (int i = 0; i < 16; i++) blk[i*8 +: 8] = held[i];
    rc = {key_r_high, key_r_low} & RClamp;
    sum = 131'(acc) + 131'(blk) + (hibit ? (131'(1) << 128) : 131'(0));
    sum = sum % 131'(PrimeP);
    acc = mulmod(130'(sum), rc);
  endtask

  task automatic predict_chunk(logic [63:0] lo, logic [63:0] hi, logic [4:0] bc, logic fin);
    int unsigned n;
    logic [127:0] data;
    data = {hi, lo};
    n = (bc > 16) ? 16 : bc;
    for (int i = 0; i < n; i++) begin
      held[held_n] = data[i*8 +: 8];
      held_n++;
      if (held_n == 16) begin
        absorb(1'b1);
        held_n = 0;
      end
    end
    if (fin) begin
      if (held_n != 0) begin
        held[held_n] = 8'h01;
        for (int i = held_n + 1; i < 16; i++) held[i] = 8'h00;
        absorb(1'b0);
      end
      tags_due.push_back(acc[127:0] + {key_s_high, key_s_low});
      acc = '0;
      held_n = 0;
    end
  endtask

  function automatic int gap();
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3, 1);
  endfunction

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_key(cfg_idx_t idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_R_LOW:  key_r_low = val;
      CFG_R_HIGH: key_r_high = val;
      CFG_S_LOW:  key_s_low = val;
      default:    key_s_high = val;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tags_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send(logic [63:0] lo, logic [63:0] hi, logic [4:0] bc, logic fin);
    int g;
    in_valid <= 1'b1;
    chunk_low <= lo;
    chunk_high <= hi;
    byte_count <= bc;
    final_chunk <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_chunk(lo, hi, bc, fin);
    g = gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rnd64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (tags_due.size() == 0) begin
        $error("tag with none expected: %h %h", tag_high, tag_low);
        errors++;
      end else begin
        logic [127:0] t;
        t = tags_due.pop_front();
        if (tag_low !== t[63:0]) begin
          $error("tag_low expected %h actual %h", t[63:0], tag_low);
          errors++;
        end
        if (tag_high !== t[127:64]) begin
          $error("tag_high expected %h actual %h", t[127:64], tag_high);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_mode && $urandom_range(3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  bc;
    logic        fin;
    bit          known;
    logic [127:0] tag;
  } row_t;

  row_t plan [$];

  initial begin
    int sent;
    key_r_low = '0; key_r_high = '0; key_s_low = '0; key_s_high = '0;
    acc = '0; held_n = 0;
    for (int i = 0; i < 16; i++) held[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero key: every tag is zero
    plan.push_back('{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 128'h0});
    plan.push_back('{'1, '1, 5'd16, 1'b1, 1'b1, 128'h0});
    plan.push_back('{'1, '1, 5'd31, 1'b1, 1'b1, 128'h0});
    foreach (plan[i]) begin
      tags_due.push_back(plan[i].tag);
      send(plan[i].lo, plan[i].hi, plan[i].bc, plan[i].fin);
      void'(tags_due.pop_back());
    end
    settle();

    // fixed r key with s at its extreme
    write_key(CFG_R_LOW, 64'h3c1a_ff86_3c6d_bc85);
    write_key(CFG_R_HIGH, 64'h1b07_7f9a_fa5e_4c33);
    write_key(CFG_S_LOW, '1);
    write_key(CFG_S_HIGH, '1);
    cfg_we <= 1'b0;
    plan.delete();
    plan.push_back('{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, '1});
    plan.push_back('{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd1, 1'b1, 1'b0, 0});
    plan.push_back('{'1, '1, 5'd15, 1'b1, 1'b0, 0});
    plan.push_back('{'1, '1, 5'd16, 1'b1, 1'b0, 0});
    plan.push_back('{'1, '1, 5'd20, 1'b0, 1'b0, 0});
    plan.push_back('{64'h0, 64'h0, 5'd0, 1'b0, 1'b0, 0});
    plan.push_back('{64'h55aa55aa55aa55aa, '1, 5'd9, 1'b0, 1'b0, 0});
    plan.push_back('{64'h0, 64'h0, 5'd7, 1'b1, 1'b0, 0});
    plan.push_back('{'1, '1, 5'd8, 1'b0, 1'b0, 0});
    plan.push_back('{'1, '1, 5'd8, 1'b0, 1'b0, 0});
    plan.push_back('{64'h0, 64'h0, 5'd0, 1'b1, 1'b0, 0});
    plan.push_back('{'1, '1, 5'd31, 1'b0, 1'b0, 0});
    plan.push_back('{'1, '1, 5'd17, 1'b0, 1'b0, 0});
    plan.push_back('{'1, '1, 5'd3, 1'b1, 1'b0, 0});
    foreach (plan[i]) begin
      if (plan[i].known) begin
        tags_due.push_back(plan[i].tag);
        send(plan[i].lo, plan[i].hi, plan[i].bc, plan[i].fin);
        void'(tags_due.pop_back());
      end else send(plan[i].lo, plan[i].hi, plan[i].bc, plan[i].fin);
    end
    settle();

    stall_mode = 1;
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_key(CFG_R_LOW, ph == 1 ? '1 : rnd64());
      write_key(CFG_R_HIGH, ph == 1 ? '1 : rnd64());
      write_key(CFG_S_LOW, ph == 2 ? '0 : rnd64());
      write_key(CFG_S_HIGH, ph == 2 ? '0 : rnd64());
      cfg_we <= 1'b0;
      stall_mode = (ph != 3);
      for (int k = 0; k < 200; k++) begin
        logic [4:0] bc;
        case ($urandom_range(5))
          0: bc = 5'($urandom_range(31));
          1: bc = 5'($urandom_range(15));
          default: bc = 5'd16;
        endcase
        send(rnd64(), rnd64(), bc, $urandom_range(5) == 0);
        sent++;
      end
      send(rnd64(), rnd64(), 5'($urandom_range(16)), 1'b1);
      settle();
    end

    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
